/* hdl/rhsv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, constants and the work item handed along the divider chain.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int unsigned ChW   = 8;          // channel width
  localparam int unsigned QuoW  = 7;          // quotient bits, one per cell
  localparam int unsigned DsrW  = ChW + QuoW - 1;
  localparam int unsigned RemW  = DsrW + 1;
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned NumCells = QuoW;

  localparam logic [HueW-1:0] HueRed   = 9'd0;
  localparam logic [HueW-1:0] HueGreen = 9'd120;
  localparam logic [HueW-1:0] HueBlue  = 9'd240;
  localparam logic [HueW-1:0] HueWrap  = 9'd360;

  localparam logic [6:0] HueScale = 7'd60;
  localparam logic [6:0] PctScale = 7'd100;
  localparam logic [8:0] Recip255 = 9'd257;   // x/255 == ((x+1)*257) >> 16

  typedef struct packed {
    logic [RemW-1:0] rem_h;
    logic [RemW-1:0] rem_s;
    logic [DsrW-1:0] dsr_h;
    logic [DsrW-1:0] dsr_s;
    logic [QuoW-1:0] quo_h;
    logic [QuoW-1:0] quo_s;
    logic [HueW-1:0] base;
    logic            neg;
    logic            grey;
    logic [PctW-1:0] bright;
    logic [ChW-1:0]  alpha;
  } rhsv_work_t;

endpackage
`default_nettype wire

/* hdl/rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// RGBA pixel to hue (degrees), saturation and value (percent), alpha kept.
// ----------------------------------------------------------------------------
// Input channel: valid_i with red_i/green_i/blue_i/alpha_i; a request is taken
// on a clock edge with valid_i high and stall_o low.
// Output channel: valid_o with hue_o/saturation_o/brightness_o/alpha_out_o; a
// result is taken on an edge with valid_o high and stall_i low.
// Path: the input stage loads on the accepting edge, then the request passes
// through seven division cells and the output register before valid_o rises.
// Throughput: one pixel per clock while the output is not stalled; every cell
// of the divider row retires one quotient bit for hue and saturation at once.
// Each stage holds its request while the next one is full and stalled, so
// empty stages keep filling while the receiver stalls; stall_o rises only
// once the whole row is full behind a stalled output.
// Reset clears all valid flags; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output      logic                        stall_o,
  input  wire logic [rhsv_pkg::ChW-1:0]    red_i,
  input  wire logic [rhsv_pkg::ChW-1:0]    green_i,
  input  wire logic [rhsv_pkg::ChW-1:0]    blue_i,
  input  wire logic [rhsv_pkg::ChW-1:0]    alpha_i,
  output      logic                        valid_o,
  input  wire logic                        stall_i,
  output      logic [rhsv_pkg::HueW-1:0]   hue_o,
  output      logic [rhsv_pkg::PctW-1:0]   saturation_o,
  output      logic [rhsv_pkg::PctW-1:0]   brightness_o,
  output      logic [rhsv_pkg::ChW-1:0]    alpha_out_o
);
  import rhsv_pkg::*;

  logic       chain_valid [NumCells+1];
  logic       chain_ready [NumCells+1];
  rhsv_work_t chain_work  [NumCells+1];

  logic            out_valid_q;
  logic            out_ready;
  logic [HueW-1:0] hue_d, hue_q;
  logic [PctW-1:0] sat_d, sat_q, bright_q;
  logic [ChW-1:0]  alpha_q;
  rhsv_work_t      last;

  rhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .alpha_i (alpha_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .work_o  (chain_work[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rhsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .work_i  (chain_work[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .work_o  (chain_work[k+1])
    );
  end

  assign out_ready              = !out_valid_q || !stall_i;
  assign chain_ready[NumCells]  = out_ready;
  assign last                   = chain_work[NumCells];

  always_comb begin
    if (last.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = last.neg ? (last.base - HueW'(last.quo_h))
                       : (last.base + HueW'(last.quo_h));
      sat_d = PctW'(last.quo_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= chain_valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && chain_valid[NumCells]) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= last.bright;
      alpha_q  <= last.alpha;
    end
  end

  assign valid_o      = out_valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;
  assign alpha_out_o  = alpha_q;

`ifndef ASSERT_OFF
  a_stall_needs_full_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) stall_o |-> (out_valid_q && stall_i)
  ) else $error("input stalled while output register is free");

  a_hue_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> (hue_q < HueWrap)
  ) else $error("hue out of range");

  a_pct_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> ((sat_q <= PctW'(PctScale)) && (bright_q <= PctW'(PctScale)))
  ) else $error("percent out of range");
`endif

endmodule
`default_nettype wire

/* hdl/rhsv_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_prep
// Input stage: picks max/min and the hue sector, forms both dividends and
// divisors and the brightness, and registers the request.
// ----------------------------------------------------------------------------
module rhsv_prep (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output      logic                       stall_o,
  input  wire logic [rhsv_pkg::ChW-1:0]   red_i,
  input  wire logic [rhsv_pkg::ChW-1:0]   green_i,
  input  wire logic [rhsv_pkg::ChW-1:0]   blue_i,
  input  wire logic [rhsv_pkg::ChW-1:0]   alpha_i,
  output      logic                       valid_o,
  input  wire logic                       ready_i,
  output      rhsv_pkg::rhsv_work_t       work_o
);
  import rhsv_pkg::*;

  logic             valid_q;
  rhsv_work_t       work_d, work_q;
  logic             adv;
  logic             red_max, green_max;
  logic [ChW-1:0]   mx, mn, spread, p, q, mag;
  logic             neg;
  logic [DsrW-1:0]  num_h;
  logic [RemW-1:0]  num_s;
  logic [RemW-1:0]  val_x;
  logic [23:0]      val_m;

  assign adv     = !valid_q || ready_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      mx = red_i;   p = green_i; q = blue_i;
    end else if (green_max) begin
      mx = green_i; p = blue_i;  q = red_i;
    end else begin
      mx = blue_i;  p = red_i;   q = green_i;
    end
    mn = (red_i <= green_i) ? red_i : green_i;
    mn = (blue_i <= mn) ? blue_i : mn;
    spread = mx - mn;
    neg    = p < q;
    mag    = neg ? (q - p) : (p - q);
    // negative side rounds toward the offset: ceil via (x + s - 1)
    num_h  = DsrW'(HueScale * mag) + (neg ? DsrW'(spread - 8'd1) : '0);
    num_s  = RemW'(PctScale * spread);
    val_x  = RemW'(PctScale * mx);
    val_m  = (24'(val_x) + 24'd1) * 24'(Recip255);

    work_d.rem_h  = RemW'(num_h);
    work_d.rem_s  = num_s;
    work_d.dsr_h  = {spread, (QuoW-1)'(0)};
    work_d.dsr_s  = {mx, (QuoW-1)'(0)};
    work_d.quo_h  = '0;
    work_d.quo_s  = '0;
    if (red_max)        work_d.base = neg ? HueWrap : HueRed;
    else if (green_max) work_d.base = HueGreen;
    else                work_d.base = HueBlue;
    work_d.neg    = neg;
    work_d.grey   = (spread == '0);
    work_d.bright = val_m[22:16];
    work_d.alpha  = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/rhsv_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_cell
// One restoring-division step for hue and saturation: retires one quotient
// bit of each and hands the item to the next cell.
// ----------------------------------------------------------------------------
module rhsv_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire rhsv_pkg::rhsv_work_t work_i,
  output      logic                 valid_o,
  input  wire logic                 ready_i,
  output      rhsv_pkg::rhsv_work_t work_o
);
  import rhsv_pkg::*;

  logic            valid_q;
  rhsv_work_t      work_d, work_q;
  logic            ge_h, ge_s;
  logic [RemW-1:0] rh, rs;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_comb begin
    ge_h = work_i.rem_h >= RemW'(work_i.dsr_h);
    ge_s = work_i.rem_s >= RemW'(work_i.dsr_s);
    rh   = ge_h ? (work_i.rem_h - RemW'(work_i.dsr_h)) : work_i.rem_h;
    rs   = ge_s ? (work_i.rem_s - RemW'(work_i.dsr_s)) : work_i.rem_s;
    work_d       = work_i;
    work_d.rem_h = {rh[RemW-2:0], 1'b0};
    work_d.rem_s = {rs[RemW-2:0], 1'b0};
    work_d.quo_h = {work_i.quo_h[QuoW-2:0], ge_h};
    work_d.quo_s = {work_i.quo_s[QuoW-2:0], ge_s};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule
`default_nettype wire
